### hw/rtl/drt_pkg.sv
// Package for the distance-vector route table: sizes, command and status codes,
// the table entry layout and small helper functions.
// No dependencies.
package drt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W = 48;
    localparam int HOPS_W = 8;
    localparam int SEQ_W = 16;
    localparam int TIME_W = 32;
    localparam int EXP_W = 5;
    localparam int STATUS_W = 4;

    localparam logic [HOPS_W-1:0] HOPS_BROKEN = '1;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ADVERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED = 4'd0,
        ST_UPDATED = 4'd1,
        ST_IGNORED = 4'd2,
        ST_FULL = 4'd3,
        ST_LOCAL = 4'd4,
        ST_FORWARD = 4'd5,
        ST_NO_ROUTE = 4'd6,
        ST_SWEPT = 4'd7,
        ST_OWN_ADVERT = 4'd8
    } status_t;

    typedef enum logic [0:0] {
        REG_OWN_ADDRESS = 1'b0,
        REG_STALE_LIMIT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_seen;
        logic [SEQ_W-1:0] seq;
        logic [HOPS_W-1:0] hops;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] dest;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [SEQ_W-1:0] round_even(input logic [SEQ_W-1:0] s);
        return s + {{(SEQ_W-1){1'b0}}, s[0]};
    endfunction

    function automatic logic [HOPS_W-1:0] hops_plus_one(input logic [HOPS_W-1:0] h);
        return (h == HOPS_BROKEN) ? HOPS_BROKEN : h + {{(HOPS_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

### hw/rtl/drt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/distance_vector_route_table_top.sv
// Top level of the distance-vector route table: command sequencer and result register.
// Depends on drt_pkg and drt_ram.
//
// The route table keeps up to TABLE_ENTRIES entries in one synchronous RAM; entry zero is
// this node, whose address, hop count and sequence number are held in registers. Each
// command beat gives exactly one result beat. A broadcast tick and a lookup of the own
// address need no table search; an advertisement or lookup searches the table linearly,
// visiting each entry in a RAM read state and then a compare and write-back state; a
// stale sweep always visits every valid entry. The result register lets the next
// command enter while a result waits. Configuration writes are always accepted and
// must only be made while the block is idle.
module distance_vector_route_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dest_address, sender_address, adv_hops, adv_sequence, now_time
    input  logic [151:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_hop, route_hops, route_sequence, expired_count, zero fill
    output logic [79:0]  m_tdata,
    // status
    output logic [3:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);
    import drt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD = 4'b0010,
        S_CHK = 4'b0100,
        S_OUT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic [ADDR_W-1:0] dest_reg, dest_next, sender_reg, sender_next;
    logic [HOPS_W-1:0] hops_in_reg, hops_in_next;
    logic [SEQ_W-1:0] seq_in_reg, seq_in_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CNT_W-1:0] idx_reg, idx_next, cnt_reg, cnt_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic [HOPS_W-1:0] hops0_reg, hops0_next;
    logic [SEQ_W-1:0] seq0_reg, seq0_next;
    logic [ADDR_W-1:0] own_reg;
    logic [TIME_W-1:0] limit_reg;

    status_t res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_nh_reg, res_nh_next;
    logic [HOPS_W-1:0] res_hops_reg, res_hops_next;
    logic [SEQ_W-1:0] res_seq_reg, res_seq_next;
    logic [EXP_W-1:0] res_exp_reg, res_exp_next;

    logic m_valid_reg, m_valid_next;
    status_t out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_nh_reg, out_nh_next;
    logic [HOPS_W-1:0] out_hops_reg, out_hops_next;
    logic [SEQ_W-1:0] out_seq_reg, out_seq_next;
    logic [EXP_W-1:0] out_exp_reg, out_exp_next;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t ram_wdata, ram_rdata, ent, adv_ent, new_ent;
    logic [HOPS_W-1:0] hops_new;
    status_t adv_status;
    logic is_zero;

    drt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tuser = out_status_reg;
    assign m_tdata = {3'b000, out_exp_reg, out_seq_reg, out_hops_reg, out_nh_reg};

    assign is_zero = (idx_reg == '0);
    assign hops_new = hops_plus_one(hops_in_reg);

    always_comb begin
        ent = ram_rdata;
        if (is_zero) begin
            ent.dest = own_reg;
            ent.next_hop = own_reg;
            ent.hops = hops0_reg;
            ent.seq = seq0_reg;
        end
    end

    always_comb begin
        adv_ent = ent;
        adv_status = ST_IGNORED;
        if (seq_in_reg > ent.seq) begin
            adv_status = ST_UPDATED;
            if (is_zero) begin
                adv_ent.seq = round_even(seq_in_reg);
            end else begin
                adv_ent.next_hop = sender_reg;
                adv_ent.hops = hops_new;
                adv_ent.seq = seq_in_reg;
                adv_ent.last_seen = now_reg;
            end
        end else if (seq_in_reg == ent.seq) begin
            if (hops_new < ent.hops) begin
                adv_status = ST_UPDATED;
                adv_ent.next_hop = sender_reg;
                adv_ent.hops = hops_new;
                adv_ent.last_seen = now_reg;
            end else if (ent.next_hop == sender_reg) begin
                adv_status = ST_UPDATED;
                adv_ent.hops = hops_new;
                adv_ent.last_seen = now_reg;
            end
        end else if (ent.dest == sender_reg) begin
            adv_status = ST_UPDATED;
            adv_ent.next_hop = sender_reg;
            adv_ent.hops = hops_new;
            adv_ent.seq = round_even(ent.seq);
            adv_ent.last_seen = now_reg;
        end
    end

    always_comb begin
        new_ent.dest = dest_reg;
        new_ent.next_hop = sender_reg;
        new_ent.hops = hops_new;
        new_ent.seq = seq_in_reg;
        new_ent.last_seen = now_reg;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        dest_next = dest_reg;
        sender_next = sender_reg;
        hops_in_next = hops_in_reg;
        seq_in_next = seq_in_reg;
        now_next = now_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        hops0_next = hops0_reg;
        seq0_next = seq0_reg;
        res_status_next = res_status_reg;
        res_nh_next = res_nh_reg;
        res_hops_next = res_hops_reg;
        res_seq_next = res_seq_reg;
        res_exp_next = res_exp_reg;
        m_valid_next = m_valid_reg;
        out_status_next = out_status_reg;
        out_nh_next = out_nh_reg;
        out_hops_next = out_hops_reg;
        out_seq_next = out_seq_reg;
        out_exp_next = out_exp_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = adv_ent;
        ram_raddr = idx_reg[IDX_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = cmd_t'(s_tuser);
                    dest_next = s_tdata[47:0];
                    sender_next = s_tdata[95:48];
                    hops_in_next = s_tdata[103:96];
                    seq_in_next = s_tdata[119:104];
                    now_next = s_tdata[151:120];
                    idx_next = (cmd_t'(s_tuser) == CMD_LOOKUP) ? CNT_W'(1) : '0;
                    exp_next = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                res_nh_next = '0;
                res_hops_next = '0;
                res_seq_next = '0;
                res_exp_next = '0;
                state_next = S_OUT;
                if (cmd_reg == CMD_TICK) begin
                    seq0_next = seq0_reg + SEQ_W'(2);
                    res_status_next = ST_OWN_ADVERT;
                    res_hops_next = hops0_reg;
                    res_seq_next = seq0_reg + SEQ_W'(2);
                end else if (cmd_reg == CMD_LOOKUP && dest_reg == own_reg) begin
                    res_status_next = ST_LOCAL;
                    res_hops_next = hops0_reg;
                    res_seq_next = seq0_reg;
                end else if (idx_reg >= cnt_reg) begin
                    case (cmd_reg)
                        CMD_ADVERT: begin
                            if (cnt_reg == CNT_W'(TABLE_ENTRIES)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                ram_wdata = new_ent;
                                cnt_next = cnt_reg + CNT_W'(1);
                                res_status_next = ST_ADDED;
                                res_hops_next = hops_new;
                                res_seq_next = seq_in_reg;
                            end
                        end
                        CMD_SWEEP: begin
                            res_status_next = ST_SWEPT;
                            res_exp_next = exp_reg;
                        end
                        default: begin
                            res_status_next = ST_NO_ROUTE;
                        end
                    endcase
                end else begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                idx_next = idx_reg + CNT_W'(1);
                state_next = S_RD;
                case (cmd_reg)
                    CMD_ADVERT: begin
                        if (ent.dest == dest_reg) begin
                            ram_we = 1'b1;
                            if (is_zero) begin
                                hops0_next = adv_ent.hops;
                                seq0_next = adv_ent.seq;
                            end
                            res_status_next = adv_status;
                            res_hops_next = adv_ent.hops;
                            res_seq_next = adv_ent.seq;
                            state_next = S_OUT;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (ent.dest == dest_reg) begin
                            res_hops_next = ent.hops;
                            res_seq_next = ent.seq;
                            if (ent.hops == HOPS_BROKEN) begin
                                res_status_next = ST_NO_ROUTE;
                            end else begin
                                res_status_next = ST_FORWARD;
                                res_nh_next = ent.next_hop;
                            end
                            state_next = S_OUT;
                        end
                    end
                    default: begin
                        if (ent.hops == HOPS_BROKEN >> (HOPS_W - 1)
                            && (now_reg - ent.last_seen) > limit_reg) begin
                            ram_we = 1'b1;
                            ram_wdata = ent;
                            ram_wdata.hops = HOPS_BROKEN;
                            ram_wdata.seq = ent.seq + SEQ_W'(1);
                            if (is_zero) begin
                                hops0_next = HOPS_BROKEN;
                                seq0_next = ent.seq + SEQ_W'(1);
                            end
                            if (exp_reg != EXP_MAX) begin
                                exp_next = exp_reg + EXP_W'(1);
                            end
                        end
                    end
                endcase
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_status_next = res_status_reg;
                    out_nh_next = res_nh_reg;
                    out_hops_next = res_hops_reg;
                    out_seq_next = res_seq_reg;
                    out_exp_next = res_exp_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= CNT_W'(1);
            hops0_reg <= '0;
            seq0_reg <= '0;
            m_valid_reg <= 1'b0;
            own_reg <= '0;
            limit_reg <= TIME_W'(10000);
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            hops0_reg <= hops0_next;
            seq0_reg <= seq0_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_index[1] == 1'b0) begin
                if (reg_index_t'(cfg_index[0]) == REG_OWN_ADDRESS) begin
                    own_reg <= cfg_data;
                end else begin
                    limit_reg <= cfg_data[TIME_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        dest_reg <= dest_next;
        sender_reg <= sender_next;
        hops_in_reg <= hops_in_next;
        seq_in_reg <= seq_in_next;
        now_reg <= now_next;
        idx_reg <= idx_next;
        exp_reg <= exp_next;
        res_status_reg <= res_status_next;
        res_nh_reg <= res_nh_next;
        res_hops_reg <= res_hops_next;
        res_seq_reg <= res_seq_next;
        res_exp_reg <= res_exp_next;
        out_status_reg <= out_status_next;
        out_nh_reg <= out_nh_next;
        out_hops_reg <= out_hops_next;
        out_seq_reg <= out_seq_next;
        out_exp_reg <= out_exp_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 && cnt_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count out of range");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_RD)
        else $error("accepted command did not start");
    a_write_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == S_RD || state_reg == S_CHK)
        else $error("table write outside command work");
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && (!m_valid_reg || m_tready) |=> m_valid_reg)
        else $error("result not presented");
`endif

endmodule
